/* rtl/prim_mst_pkg.sv */
// Shared types and constants of the minimum spanning tree block.
// Item structs, field widths, register reset value and sequencer states.
// No dependencies.
package prim_mst_pkg;

  localparam int MST_MAX_NODES   = 16;
  localparam int MST_WEIGHT_BITS = 8;

  localparam int NODE_FIELD_W   = 4;
  localparam int WEIGHT_FIELD_W = 8;
  localparam int CFG_W          = 5;

  localparam logic [CFG_W-1:0] NODE_COUNT_RST = CFG_W'(16);

  typedef struct packed {
    logic [NODE_FIELD_W-1:0]   node_a;
    logic [NODE_FIELD_W-1:0]   node_b;
    logic [WEIGHT_FIELD_W-1:0] edge_weight;
    logic                      last_edge;
  } in_item_t;

  typedef struct packed {
    logic [NODE_FIELD_W-1:0]   tree_from;
    logic [NODE_FIELD_W-1:0]   tree_to;
    logic [WEIGHT_FIELD_W-1:0] tree_weight;
    logic                      edge_valid;
    logic                      disconnected;
    logic                      run_last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_ABS,
    ST_DRAIN,
    ST_PICK
  } mst_state_t;

endpackage

/* rtl/prim_mst_wmem.sv */
// Edge weight memory: one entry per unordered node pair, absent flag on top.
// One write port, one read port, registered read data. Uses no package.
module prim_mst_wmem #(
  parameter int MAX_NODES   = 16,
  parameter int WEIGHT_BITS = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [$clog2(MAX_NODES*MAX_NODES)-1:0] waddr,
  input  logic [WEIGHT_BITS:0]                   wdata,
  input  logic [$clog2(MAX_NODES*MAX_NODES)-1:0] raddr,
  output logic [WEIGHT_BITS:0]                   rdata
);
  localparam int DEPTH = MAX_NODES * MAX_NODES;

  logic [WEIGHT_BITS:0] mem [DEPTH];
  logic [WEIGHT_BITS:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/prim_mst_kmem.sv */
// Best key and parent memory, one entry per node, with per-entry valid bits.
// An entry not written since the last clear reads as absent key, parent 0.
// Uses no package.
module prim_mst_kmem #(
  parameter int MAX_NODES   = 16,
  parameter int WEIGHT_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clr,
  input  logic                         we,
  input  logic [$clog2(MAX_NODES)-1:0] waddr,
  input  logic [WEIGHT_BITS:0]         wkey,
  input  logic [$clog2(MAX_NODES)-1:0] wpar,
  input  logic [$clog2(MAX_NODES)-1:0] raddr,
  output logic [WEIGHT_BITS:0]         rkey,
  output logic [$clog2(MAX_NODES)-1:0] rpar
);
  localparam int NW = $clog2(MAX_NODES);
  localparam int KW = WEIGHT_BITS + 1;
  localparam logic [KW-1:0] ABSENT = {1'b1, {WEIGHT_BITS{1'b0}}};

  logic [NW+KW-1:0] mem [MAX_NODES];
  logic [NW+KW-1:0] rd_r;
  logic             rvld_r;
  logic [MAX_NODES-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wpar, wkey};
    end
    rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      rvld_r <= vld_r[raddr];
    end
  end

  assign rkey = rvld_r ? rd_r[KW-1:0] : ABSENT;
  assign rpar = rvld_r ? rd_r[NW+KW-1:KW] : '0;

endmodule

/* rtl/prim_mst_seq.sv */
// Sequencer: edge load, one relax-and-select pass per tree node, clear sweep.
// Drives both memories and the registered result port. Uses prim_mst_pkg.
module prim_mst_seq #(
  parameter int MAX_NODES   = 16,
  parameter int WEIGHT_BITS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  prim_mst_pkg::in_item_t                 in_data,
  input  logic [$clog2(MAX_NODES):0]             n_eff,
  output logic                                   busy,
  output logic                                   out_valid,
  output prim_mst_pkg::out_item_t                out_data,
  output logic                                   w_we,
  output logic [$clog2(MAX_NODES*MAX_NODES)-1:0] w_waddr,
  output logic [WEIGHT_BITS:0]                   w_wdata,
  output logic [$clog2(MAX_NODES*MAX_NODES)-1:0] w_raddr,
  input  logic [WEIGHT_BITS:0]                   w_rdata,
  output logic                                   k_clr,
  output logic                                   k_we,
  output logic [$clog2(MAX_NODES)-1:0]           k_waddr,
  output logic [WEIGHT_BITS:0]                   k_wkey,
  output logic [$clog2(MAX_NODES)-1:0]           k_wpar,
  output logic [$clog2(MAX_NODES)-1:0]           k_raddr,
  input  logic [WEIGHT_BITS:0]                   k_rkey,
  input  logic [$clog2(MAX_NODES)-1:0]           k_rpar
);
  import prim_mst_pkg::*;

  localparam int NW = $clog2(MAX_NODES);
  localparam int AW = $clog2(MAX_NODES * MAX_NODES);
  localparam int KW = WEIGHT_BITS + 1;
  localparam logic [KW-1:0] ABSENT   = {1'b1, {WEIGHT_BITS{1'b0}}};
  localparam logic [AW-1:0] CLR_LAST = AW'(MAX_NODES * MAX_NODES - 1);

  function automatic logic [AW-1:0] pair_addr(input logic [NW-1:0] x,
                                              input logic [NW-1:0] y);
    logic [NW-1:0] lo;
    logic [NW-1:0] hi;
    lo = (x < y) ? x : y;
    hi = (x < y) ? y : x;
    return AW'(int'(lo) * MAX_NODES + int'(hi));
  endfunction

  mst_state_t state_r, state_nxt;

  logic [AW-1:0]          clr_r;
  logic [AW-1:0]          ld_addr_r;
  logic [WEIGHT_BITS-1:0] ld_w_r;
  logic                   ld_ok_r;
  logic                   ld_last_r;
  logic [NW-1:0]          u_r;
  logic [NW-1:0]          v_r;
  logic [MAX_NODES-1:0]   visited_r;
  logic [NW:0]            reached_r;
  logic                   p_vld_r;
  logic [NW-1:0]          p_u_r;
  logic [KW-1:0]          low_r;
  logic [NW-1:0]          pick_r;
  logic [NW-1:0]          pick_par_r;
  logic                   found_r;
  logic                   pend_vld_r;
  logic [NW-1:0]          pend_from_r;
  logic [NW-1:0]          pend_to_r;
  logic [WEIGHT_BITS-1:0] pend_w_r;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;

  logic          accept;
  logic [NW-1:0] in_a;
  logic [NW-1:0] in_b;
  logic          in_ok;
  logic [NW-1:0] u_last;
  logic          p_unvis;
  logic          upd;
  logic [KW-1:0] nkey;
  logic [NW-1:0] npar;
  logic          better;

  assign accept = start && (state_r == ST_IDLE);
  assign in_a   = NW'(in_data.node_a);
  assign in_b   = NW'(in_data.node_b);
  assign in_ok  = (in_data.node_a != in_data.node_b) &&
                  (int'(in_data.node_a) < int'(n_eff)) &&
                  (int'(in_data.node_b) < int'(n_eff));
  assign u_last = NW'(n_eff - 1'b1);

  // relax stage: memory data of node p_u_r against row v_r
  assign p_unvis = !visited_r[p_u_r];
  assign upd     = p_vld_r && p_unvis && (w_rdata < k_rkey);
  assign nkey    = upd ? w_rdata : k_rkey;
  assign npar    = upd ? v_r : k_rpar;
  assign better  = p_vld_r && p_unvis && (nkey < low_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == CLR_LAST) state_nxt = ST_IDLE;
      ST_IDLE:  if (start) state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ld_last_r ? ST_ABS : ST_IDLE;
      ST_ABS:   if (u_r == u_last) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_PICK;
      ST_PICK:  state_nxt = found_r ? ST_ABS : ST_CLEAR;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    busy    = (state_r != ST_IDLE);
    w_we    = 1'b0;
    w_waddr = ld_addr_r;
    w_wdata = {1'b0, ld_w_r};
    w_raddr = (state_r == ST_IDLE) ? pair_addr(in_a, in_b) : pair_addr(v_r, u_r);
    k_clr   = (state_r == ST_PICK) && !found_r;
    k_we    = upd;
    k_waddr = p_u_r;
    k_wkey  = w_rdata;
    k_wpar  = v_r;
    k_raddr = u_r;

    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;

    case (state_r)
      ST_CLEAR: begin
        w_we    = 1'b1;
        w_waddr = clr_r;
        w_wdata = ABSENT;
      end
      ST_LOAD: begin
        w_we = ld_ok_r && ({1'b0, ld_w_r} < w_rdata);
      end
      ST_PICK: begin
        // a tree edge is held until the next pass shows whether it is the final one
        out_valid_nxt = pend_vld_r || !found_r;
        if (pend_vld_r) begin
          out_data_nxt.tree_from   = NODE_FIELD_W'(pend_from_r);
          out_data_nxt.tree_to     = NODE_FIELD_W'(pend_to_r);
          out_data_nxt.tree_weight = WEIGHT_FIELD_W'(pend_w_r);
          out_data_nxt.edge_valid  = 1'b1;
        end
        out_data_nxt.run_last     = !found_r;
        out_data_nxt.disconnected = !found_r && (reached_r < n_eff);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      ld_ok_r     <= 1'b0;
      ld_last_r   <= 1'b0;
      u_r         <= '0;
      v_r         <= '0;
      visited_r   <= '0;
      reached_r   <= '0;
      p_vld_r     <= 1'b0;
      found_r     <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      p_vld_r     <= (state_r == ST_ABS);
      p_u_r       <= u_r;

      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end

      if (accept) begin
        ld_addr_r <= pair_addr(in_a, in_b);
        ld_w_r    <= WEIGHT_BITS'(in_data.edge_weight);
        ld_ok_r   <= in_ok;
        ld_last_r <= in_data.last_edge;
      end

      if (state_r == ST_ABS) begin
        u_r <= u_r + 1'b1;
      end

      if (better) begin
        low_r      <= nkey;
        pick_r     <= p_u_r;
        pick_par_r <= npar;
        found_r    <= 1'b1;
      end

      // start the run from node 0
      if (state_r == ST_LOAD && ld_last_r) begin
        u_r          <= '0;
        v_r          <= '0;
        visited_r[0] <= 1'b1;
        reached_r    <= (NW+1)'(1);
        pend_vld_r   <= 1'b0;
        low_r        <= ABSENT;
        found_r      <= 1'b0;
      end

      if (state_r == ST_PICK) begin
        if (found_r) begin
          pend_vld_r        <= 1'b1;
          pend_from_r       <= pick_par_r;
          pend_to_r         <= pick_r;
          pend_w_r          <= low_r[WEIGHT_BITS-1:0];
          v_r               <= pick_r;
          visited_r[pick_r] <= 1'b1;
          reached_r         <= reached_r + 1'b1;
          u_r               <= '0;
          low_r             <= ABSENT;
          found_r           <= 1'b0;
        end else begin
          visited_r  <= '0;
          pend_vld_r <= 1'b0;
          clr_r      <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_nxt) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/prim_minimum_spanning_tree.sv */
// Minimum spanning tree (Prim) over up to MAX_NODES nodes; top level.
// Edge item: read the pair entry, then write back the lighter weight.
// Last edge: one relax/select pass per tree node (one weight-memory read per node);
// one result per added node, then a clear sweep of all weight entries.
// Reset (rst_n low, synchronous) also runs the clear sweep; busy stays high.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
module prim_minimum_spanning_tree #(
  parameter int MAX_NODES   = prim_mst_pkg::MST_MAX_NODES,
  parameter int WEIGHT_BITS = prim_mst_pkg::MST_WEIGHT_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  prim_mst_pkg::in_item_t            in_data,
  output logic                              out_valid,
  output prim_mst_pkg::out_item_t           out_data,
  input  logic                              cfg_we,
  input  logic [prim_mst_pkg::CFG_W-1:0]    cfg_wdata
);
  import prim_mst_pkg::*;

  localparam int NW = $clog2(MAX_NODES);
  localparam int AW = $clog2(MAX_NODES * MAX_NODES);

  // node_count register; user must write it only while idle (block does not check)
  logic [CFG_W-1:0] node_count_r;
  logic [NW:0]      n_eff;

  logic                   w_we;
  logic [AW-1:0]          w_waddr;
  logic [WEIGHT_BITS:0]   w_wdata;
  logic [AW-1:0]          w_raddr;
  logic [WEIGHT_BITS:0]   w_rdata;
  logic                   k_clr;
  logic                   k_we;
  logic [NW-1:0]          k_waddr;
  logic [WEIGHT_BITS:0]   k_wkey;
  logic [NW-1:0]          k_wpar;
  logic [NW-1:0]          k_raddr;
  logic [WEIGHT_BITS:0]   k_rkey;
  logic [NW-1:0]          k_rpar;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
    end else if (cfg_we) begin
      node_count_r <= cfg_wdata;
    end
  end

  // clamp: zero acts as one node, anything above the store size as the store size
  always_comb begin
    if (node_count_r == '0) begin
      n_eff = (NW+1)'(1);
    end else if (int'(node_count_r) > MAX_NODES) begin
      n_eff = (NW+1)'(MAX_NODES);
    end else begin
      n_eff = (NW+1)'(node_count_r);
    end
  end

  // pair weights, kept once per unordered pair
  prim_mst_wmem #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_wmem (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  // best connecting key and parent per node for the running tree
  prim_mst_kmem #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_kmem (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (k_clr),
    .we    (k_we),
    .waddr (k_waddr),
    .wkey  (k_wkey),
    .wpar  (k_wpar),
    .raddr (k_raddr),
    .rkey  (k_rkey),
    .rpar  (k_rpar)
  );

  // load, per-node relax/select passes, result ordering and clear sweep
  prim_mst_seq #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .n_eff     (n_eff),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data),
    .w_we      (w_we),
    .w_waddr   (w_waddr),
    .w_wdata   (w_wdata),
    .w_raddr   (w_raddr),
    .w_rdata   (w_rdata),
    .k_clr     (k_clr),
    .k_we      (k_we),
    .k_waddr   (k_waddr),
    .k_wkey    (k_wkey),
    .k_wpar    (k_wpar),
    .k_raddr   (k_raddr),
    .k_rkey    (k_rkey),
    .k_rpar    (k_rpar)
  );

endmodule

/* rtl/prim_mst_chk.sv */
// Port-level checker for prim_minimum_spanning_tree, bound to the top level.
// Uses prim_mst_pkg for the item types.
module prim_mst_chk (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic                    out_valid,
  input prim_mst_pkg::out_item_t out_data
);
  import prim_mst_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobed while idle");

  a_empty_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.edge_valid |-> out_data.run_last)
    else $error("empty result not marked final");

  a_disc_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.disconnected |-> out_data.run_last)
    else $error("disconnected flag on a non-final result");

  a_final_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.run_last |=> busy && !out_valid)
    else $error("final result not followed by clear sweep");

endmodule

bind prim_minimum_spanning_tree prim_mst_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
